>>> src/rosg_pkg.sv
// shared types and constants for the rectangle outline span generator
`default_nettype none

package rosg_pkg;

    localparam int unsigned XW = 8;
    localparam int unsigned YW = 8;
    localparam int unsigned WW = 16;
    localparam int unsigned HW = 8;
    localparam int unsigned CW = 8;
    localparam int unsigned LW = 9;
    localparam int unsigned SEGW = 7;
    localparam int unsigned ADDW = 17;

    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [ADDW-1:0] SCREEN_COLS = ADDW'(256);
    localparam logic [ADDW-1:0] SCREEN_ROWS = ADDW'(192);
    localparam logic [YW-1:0]   LAST_ROW    = YW'(191);
    localparam logic [SEGW-1:0] BANK_ROWS   = SEGW'(64);

    // one vertical piece, cut at the next bank boundary
    typedef struct packed {
        logic [SEGW-1:0] len;
        logic [HW-1:0]   rem_next;
        logic            last;
    } seg_t;

endpackage

`default_nettype wire

>>> src/rosg_seg.sv
// vertical edge cutter: piece length up to the next bank boundary
`default_nettype none

module rosg_seg (
    input  wire logic [5:0]             row_lo,
    input  wire logic [rosg_pkg::HW-1:0] rem,
    output rosg_pkg::seg_t              seg
);
    import rosg_pkg::*;

    logic [SEGW-1:0] room;

    always_comb begin
        room         = BANK_ROWS - {1'b0, row_lo};
        seg.last     = (rem <= {1'b0, room});
        seg.len      = seg.last ? rem[SEGW-1:0] : room;
        seg.rem_next = rem - {1'b0, seg.len};
    end

endmodule

`default_nettype wire

>>> src/rect_outline_span_generator.sv
// rectangle outline to fill span converter, top level
//
// A rectangle request enters on the s_ channel (tvalid/tready/tdata) and
// leaves as up to eight fill spans on the m_ channel: top edge, left edge
// pieces, bottom edge, right edge pieces. Vertical edges are cut at the
// 64-row bank boundaries; m_tlast marks the final span of a request and
// m_tuser says whether a span runs down a column.
// One request is handled at a time: s_tready is high only while the
// sequencer is idle. A single 17-bit adder is shared by the clip checks,
// the clip fixes and the row/column updates, so a request steps through
// the width check, width fix, height check and height fix before its
// first span is registered, and a right edge has its column set in a
// separate step; a rejected request returns to idle from the width check.
// Spans pass through one output register, so the next request may be
// taken while the last span still waits. When the receiver holds
// m_tready low the sequencer waits with that span held.
// Reset (aresetn low, synchronous) returns to idle with no span pending.
`default_nettype none

module rect_outline_span_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // left_x, top_y, rect_width, rect_height, fill_color
    input  wire logic [rosg_pkg::S_DATA_W-1:0] s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // bank_section, span_row, span_column, span_length, span_color, zero pad
    output      logic [rosg_pkg::M_DATA_W-1:0] m_tdata,
    // is_vertical
    output      logic                          m_tuser,
    output      logic                          m_tlast
);
    import rosg_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CHK_W  = 10'b00_0000_0010,
        ST_FIX_W  = 10'b00_0000_0100,
        ST_CHK_H  = 10'b00_0000_1000,
        ST_FIX_H  = 10'b00_0001_0000,
        ST_TOP    = 10'b00_0010_0000,
        ST_LEFT   = 10'b00_0100_0000,
        ST_BOTTOM = 10'b00_1000_0000,
        ST_RSET   = 10'b01_0000_0000,
        ST_RIGHT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic [CW-1:0] color_reg, color_next;
    logic          clipw_reg, clipw_next;
    logic          cliph_reg, cliph_next;
    logic [YW-1:0] row_reg, row_next;
    logic [HW-1:0] rem_reg, rem_next;
    logic [XW-1:0] col_reg, col_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;

    // shared adder
    logic [ADDW-1:0] add_a, add_b, add_sum;
    logic            add_ci;

    seg_t seg;

    logic          out_free;
    logic          emit;
    logic [YW-1:0] e_row;
    logic [XW-1:0] e_col;
    logic [LW-1:0] e_len;
    logic          e_vert;
    logic          e_last;
    logic          reject;

    rosg_seg u_seg (
        .row_lo (row_reg[5:0]),
        .rem    (rem_reg),
        .seg    (seg)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign add_sum  = add_a + add_b + {{(ADDW-1){1'b0}}, add_ci};
    assign reject   = (y_reg > LAST_ROW) || (w_reg == '0) || (h_reg == '0);

    // operand selection for the shared adder
    always_comb begin
        add_a  = '0;
        add_b  = '0;
        add_ci = 1'b0;
        case (state_reg)
            ST_CHK_W: begin
                add_a = ADDW'(x_reg);
                add_b = ADDW'(w_reg);
            end
            ST_FIX_W: begin
                add_a  = SCREEN_COLS;
                add_b  = ~ADDW'(x_reg);
                add_ci = 1'b1;
            end
            ST_CHK_H: begin
                add_a = ADDW'(y_reg);
                add_b = ADDW'(h_reg);
            end
            ST_FIX_H: begin
                add_a  = SCREEN_ROWS;
                add_b  = ~ADDW'(y_reg);
                add_ci = 1'b1;
            end
            ST_LEFT, ST_RIGHT: begin
                add_a = ADDW'(row_reg);
                add_b = ADDW'(seg.len);
            end
            ST_BOTTOM: begin
                add_a = ADDW'(y_reg);
                add_b = ADDW'(h_reg - 1'b1);
            end
            ST_RSET: begin
                add_a = ADDW'(x_reg);
                add_b = ADDW'(w_reg[LW-1:0] - 1'b1);
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        color_next   = color_reg;
        clipw_next   = clipw_reg;
        cliph_next   = cliph_reg;
        row_next     = row_reg;
        rem_next     = rem_reg;
        col_next     = col_reg;
        emit         = 1'b0;
        e_row        = row_reg;
        e_col        = col_reg;
        e_len        = LW'(seg.len);
        e_vert       = 1'b1;
        e_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata[7:0];
                    y_next     = s_tdata[15:8];
                    w_next     = s_tdata[31:16];
                    h_next     = s_tdata[39:32];
                    color_next = s_tdata[47:40];
                    state_next = ST_CHK_W;
                end
            end
            ST_CHK_W: begin
                clipw_next = (add_sum > SCREEN_COLS);
                state_next = reject ? ST_IDLE : ST_FIX_W;
            end
            ST_FIX_W: begin
                if (clipw_reg) begin
                    w_next = WW'(add_sum[LW-1:0]);
                end
                state_next = ST_CHK_H;
            end
            ST_CHK_H: begin
                cliph_next = (add_sum > SCREEN_ROWS);
                state_next = ST_FIX_H;
            end
            ST_FIX_H: begin
                if (cliph_reg) begin
                    h_next = add_sum[HW-1:0];
                end
                state_next = ST_TOP;
            end
            ST_TOP: begin
                e_row  = y_reg;
                e_col  = x_reg;
                e_len  = w_reg[LW-1:0];
                e_vert = 1'b0;
                if (out_free) begin
                    emit       = 1'b1;
                    row_next   = y_reg;
                    rem_next   = h_reg;
                    col_next   = x_reg;
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT: begin
                e_last = seg.last && cliph_reg && clipw_reg;
                if (out_free) begin
                    emit     = 1'b1;
                    row_next = add_sum[YW-1:0];
                    rem_next = seg.rem_next;
                    if (seg.last) begin
                        if (!cliph_reg) begin
                            state_next = ST_BOTTOM;
                        end else if (!clipw_reg) begin
                            state_next = ST_RSET;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_BOTTOM: begin
                e_row  = add_sum[YW-1:0];
                e_col  = x_reg;
                e_len  = w_reg[LW-1:0];
                e_vert = 1'b0;
                e_last = clipw_reg;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = clipw_reg ? ST_IDLE : ST_RSET;
                end
            end
            ST_RSET: begin
                col_next   = add_sum[XW-1:0];
                row_next   = y_reg;
                rem_next   = h_reg;
                state_next = ST_RIGHT;
            end
            ST_RIGHT: begin
                e_last = seg.last;
                if (out_free) begin
                    emit     = 1'b1;
                    row_next = add_sum[YW-1:0];
                    rem_next = seg.rem_next;
                    if (seg.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {7'b0, color_reg, e_len, e_col, e_row[5:0], e_row[7:6]};
            m_user_next  = e_vert;
            m_last_next  = e_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        color_reg  <= color_next;
        clipw_reg  <= clipw_next;
        cliph_reg  <= cliph_next;
        row_reg    <= row_next;
        rem_reg    <= rem_next;
        col_reg    <= col_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the rectangle outline span generator
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rosg_pkg::*;

    localparam int unsigned LAST_COL    = 255;
    localparam int unsigned RANDOM_RECTS = 160;
    localparam int unsigned CALM_RECTS   = 30;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [1:0] bank;
        logic [5:0] row;
        logic [7:0] col;
        logic [8:0] len;
        logic       vert;
        logic [7:0] color;
        logic       last;
    } span_t;

    class span_board;
        span_t       spans[$];
        int unsigned errors = 0;

        function void push_span(int unsigned row, int unsigned col, int unsigned len,
                                bit vert, logic [7:0] color);
            span_t s;
            s.bank  = 2'(row >> 6);
            s.row   = 6'(row);
            s.col   = 8'(col);
            s.len   = 9'(len);
            s.vert  = vert;
            s.color = color;
            s.last  = 1'b0;
            spans.push_back(s);
        endfunction

        // vertical edge, cut wherever it crosses into the next bank
        function void push_column(int unsigned col, int unsigned row, int unsigned hgt,
                                  logic [7:0] color);
            int unsigned room;
            int unsigned piece;
            while (hgt > 0) begin
                room  = BANK_ROWS - (row % BANK_ROWS);
                piece = (hgt < room) ? hgt : room;
                push_span(row, col, piece, 1'b1, color);
                row += piece;
                hgt -= piece;
            end
        endfunction

        // works out the outline spans of one accepted rectangle request
        function void note_rect(logic [7:0] x, logic [7:0] y, logic [15:0] w,
                                logic [7:0] h, logic [7:0] color);
            int unsigned wid;
            int unsigned hgt;
            bit          clip_w;
            bit          clip_h;
            wid    = w;
            hgt    = h;
            clip_w = 1'b0;
            clip_h = 1'b0;
            if (y > LAST_ROW || w == 0 || h == 0)
                return;
            if (x + wid - 1 > LAST_COL) begin
                wid    = LAST_COL + 1 - x;
                clip_w = 1'b1;
            end
            if (y + hgt - 1 > LAST_ROW) begin
                hgt    = LAST_ROW + 1 - y;
                clip_h = 1'b1;
            end
            push_span(y, x, wid, 1'b0, color);
            push_column(x, y, hgt, color);
            if (!clip_h)
                push_span(y + hgt - 1, x, wid, 1'b0, color);
            if (!clip_w)
                push_column(x + wid - 1, y, hgt, color);
            spans[spans.size()-1].last = 1'b1;
        endfunction

        function void compare(string field, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s: expected %0d, got %0d", field, exp, act);
                errors++;
            end
        endfunction

        function void check_span(span_t got);
            span_t exp;
            if (spans.size() == 0) begin
                $error("span with no request outstanding: row %0d col %0d len %0d",
                       got.row, got.col, got.len);
                errors++;
                return;
            end
            exp = spans.pop_front();
            compare("bank_section", exp.bank, got.bank);
            compare("span_row", exp.row, got.row);
            compare("span_column", exp.col, got.col);
            compare("span_length", exp.len, got.len);
            compare("is_vertical", exp.vert, got.vert);
            compare("span_color", exp.color, got.color);
            compare("last_span", exp.last, got.last);
        endfunction

        function int unsigned pending();
            return spans.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    span_board   board = new;
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_request;
    int unsigned cycles;

    rect_outline_span_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // span monitor
    always @(posedge aclk) begin
        span_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.bank  = m_tdata[1:0];
            got.row   = m_tdata[7:2];
            got.col   = m_tdata[15:8];
            got.len   = m_tdata[24:16];
            got.color = m_tdata[32:25];
            got.vert  = m_tuser;
            got.last  = m_tlast;
            board.check_span(got);
        end
    end

    // span receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_tready = 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // offer one rectangle request, starting and ending on a falling edge
    task automatic send_rect(logic [7:0] x, logic [7:0] y, logic [15:0] w,
                             logic [7:0] h, logic [7:0] color);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {color, h, w, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_rect(x, y, w, h, color);
        @(negedge aclk);
    endtask

    task automatic send_random_rect();
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] w;
        logic [7:0]  h;
        int unsigned pick;
        x    = 8'($urandom);
        y    = 8'($urandom_range(0, LAST_ROW));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            w = 16'($urandom_range(1, 64));
        else if (pick < 85)
            w = 16'($urandom_range(1, 300));
        else
            w = 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 9) < 7)
            h = 8'($urandom_range(1, 80));
        else
            h = 8'($urandom_range(1, 255));
        // some noise: anything at all, rejects included
        if ($urandom_range(0, 99) < 20) begin
            y = 8'($urandom);
            w = 16'($urandom);
            h = 8'($urandom);
        end
        send_rect(x, y, w, h, 8'($urandom));
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_request = 1'b0;
        cycles       = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed corners
        send_rect(8'd0, 8'd0, 16'd256, 8'd192, 8'h00);      // whole screen, three banks
        send_rect(8'd255, 8'd191, 16'd1, 8'd1, 8'hFF);      // bottom right pixel
        send_rect(8'd10, 8'd192, 16'd10, 8'd10, 8'h11);     // top below the screen
        send_rect(8'd10, 8'd255, 16'd10, 8'd10, 8'h22);
        send_rect(8'd10, 8'd10, 16'd0, 8'd5, 8'h33);        // zero width
        send_rect(8'd10, 8'd10, 16'd5, 8'd0, 8'h44);        // zero height
        send_rect(8'd200, 8'd100, 16'hFFFF, 8'd50, 8'h55);  // right side clipped
        send_rect(8'd5, 8'd150, 16'd20, 8'd255, 8'h66);     // bottom side clipped
        send_rect(8'd128, 8'd128, 16'hFFFF, 8'd255, 8'h77); // both clipped
        send_rect(8'd40, 8'd20, 16'd30, 8'd1, 8'h88);       // single row
        send_rect(8'd77, 8'd10, 16'd1, 8'd40, 8'h99);       // single column
        send_rect(8'd0, 8'd60, 16'd8, 8'd10, 8'hAA);        // crosses into the middle bank
        send_rect(8'd1, 8'd63, 16'd3, 8'd2, 8'hBB);         // straddles the boundary
        send_rect(8'd2, 8'd64, 16'd3, 8'd64, 8'hCC);        // fills the middle bank exactly
        send_rect(8'd3, 8'd127, 16'd4, 8'd65, 8'hDD);       // ends on the last row
        send_rect(8'd0, 8'd0, 16'h8000, 8'd1, 8'hEE);
        send_rect(8'd85, 8'd170, 16'h5555, 8'd22, 8'h5A);
        send_rect(8'd170, 8'd85, 16'h00AA, 8'hAA, 8'hA5);
        send_rect(8'd255, 8'd0, 16'd2, 8'd192, 8'h01);      // one column after clipping
        send_rect(8'd0, 8'd191, 16'd256, 8'd2, 8'h80);

        // stall the span side for a long stretch while requests keep coming
        hold_request = 1'b1;
        for (int i = 0; i < RANDOM_RECTS; i++) begin
            if (i == RANDOM_RECTS - CALM_RECTS) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            send_random_rect();
        end
        s_tvalid = 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
